// ----- rtl/mouse_report_button_events_defines.svh -----
// Assertion macros for the mouse report button event block.
// Used by the top level; expects i_clk and i_rst_n in the enclosing scope.
`ifndef MOUSE_REPORT_BUTTON_EVENTS_DEFINES_SVH
`define MOUSE_REPORT_BUTTON_EVENTS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MRBE_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MRBE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mrbe_pkg.sv -----
// Shared constants and types of the mouse report button event block.
// No dependencies; imported by every module of the block.
package mrbe_pkg;

    localparam int SCREEN_WIDTH  = 1920;
    localparam int SCREEN_HEIGHT = 1080;
    localparam int HALF_W = (SCREEN_WIDTH / 2 < 1) ? 1 : SCREEN_WIDTH / 2;
    localparam int HALF_H = (SCREEN_HEIGHT / 2 < 1) ? 1 : SCREEN_HEIGHT / 2;

    localparam int NUM_BUTTONS = 7;
    localparam int BTN_IDX_W   = 3;
    localparam int DEV_W       = 4;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int POS_W       = 32;
    localparam int CUR_W       = 16;

    // Bit-serial multipliers: one multiplier bit per cycle.
    localparam int MUL_STEPS   = 16;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
    localparam int SCL_CNT_W   = $clog2(MUL_STEPS + 1);
    localparam int ROT_TERM_W  = POS_W + 2;
    localparam int ROT_HI_W    = ROT_TERM_W + 1;
    localparam int ROT_W       = ROT_HI_W + MUL_STEPS;
    localparam int ROT_CLAMP_SH = 46;
    localparam int CLAMP_W     = ROT_CLAMP_SH + 2;
    localparam logic signed [ROT_W-1:0] CLAMP_HI = ROT_W'(1) << ROT_CLAMP_SH;
    localparam logic signed [ROT_W-1:0] CLAMP_LO = -CLAMP_HI;
    localparam int SCL_HI_W    = CLAMP_W + 1;
    localparam int NUM_W       = SCL_HI_W + MUL_STEPS;

    // Origin and screen center, aligned to bit 16 of the scaled product.
    localparam int BIAS_W  = 24;
    localparam logic signed [BIAS_W-1:0] BIAS_CX = BIAS_W'(HALF_W * 64);
    localparam logic signed [BIAS_W-1:0] BIAS_CY = BIAS_W'(HALF_H * 64);

    // Divisors of the normalization, one quotient bit per cycle.
    localparam int DIV_X   = HALF_W * 128;
    localparam int DIV_Y   = HALF_H * 128;
    localparam int DIV_W   = $clog2(((DIV_X > DIV_Y) ? DIV_X : DIV_Y) + 1);
    localparam int Q_W     = CUR_W - 1;
    localparam int REM_W   = DIV_W + Q_W;
    localparam int DIV_CNT_W = $clog2(Q_W);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ROT_COS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_SIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUR_OFS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID = 3'd5;

    localparam logic [CFG_W-1:0] RST_ROT_COS = 16'd16384;
    localparam logic [CFG_W-1:0] RST_ROT_SIN = 16'd0;
    localparam logic [CFG_W-1:0] RST_SENS    = 16'd256;
    localparam logic [CFG_W-1:0] RST_CUR_OFS = 16'd270;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 40;

    typedef struct packed {
        logic              pad;
        logic signed [15:0] origin_y;
        logic signed [15:0] origin_x;
        logic [6:0]        buttons;
        logic signed [15:0] dy;
        logic signed [15:0] dx;
    } t_in_data;

    typedef struct packed {
        logic signed [15:0] cursor_y;
        logic signed [15:0] cursor_x;
        logic              pressed;
        logic [2:0]        button_index;
        logic [3:0]        device;
    } t_out_data;

endpackage

// ----- rtl/mrbe_rot.sv -----
// Bit-serial rotation of the position by the cosine and sine registers.
// Depends on mrbe_pkg; one bit of cos and sin per cycle.
module mrbe_rot (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [mrbe_pkg::POS_W-1:0]      i_mx,
    input  logic signed [mrbe_pkg::POS_W-1:0]      i_my,
    input  logic signed [mrbe_pkg::CFG_W-1:0]      i_cos,
    input  logic signed [mrbe_pkg::CFG_W-1:0]      i_sin,
    output logic                                   o_done,
    output logic signed [mrbe_pkg::ROT_W-1:0]      o_rx,
    output logic signed [mrbe_pkg::ROT_W-1:0]      o_ry
);
    import mrbe_pkg::*;

    logic                        r_busy;
    logic                        r_done;
    logic [MUL_CNT_W-1:0]        r_cnt;
    logic [POS_W-1:0]            r_mx;
    logic [POS_W-1:0]            r_my;
    logic [CFG_W-1:0]            r_cos;
    logic [CFG_W-1:0]            r_sin;
    logic [ROT_HI_W-1:0]         r_ax;
    logic [ROT_HI_W-1:0]         r_ay;
    logic [MUL_STEPS-1:0]        r_lx;
    logic [MUL_STEPS-1:0]        r_ly;

    logic                        last_step;
    logic [ROT_TERM_W-1:0]       mx_e;
    logic [ROT_TERM_W-1:0]       my_e;
    logic [ROT_TERM_W-1:0]       term_x;
    logic [ROT_TERM_W-1:0]       term_y;
    logic [ROT_HI_W:0]           sum_x;
    logic [ROT_HI_W:0]           sum_y;

    assign last_step = (r_cnt == MUL_CNT_W'(MUL_STEPS - 1));

    always_comb begin
        mx_e   = {{(ROT_TERM_W-POS_W){r_mx[POS_W-1]}}, r_mx};
        my_e   = {{(ROT_TERM_W-POS_W){r_my[POS_W-1]}}, r_my};
        term_x = (r_cos[0] ? mx_e : '0) - (r_sin[0] ? my_e : '0);
        term_y = (r_sin[0] ? mx_e : '0) + (r_cos[0] ? my_e : '0);
        // The top bit of a two's complement multiplier weighs negative.
        if (last_step) begin
            term_x = -term_x;
            term_y = -term_y;
        end
        sum_x = {r_ax[ROT_HI_W-1], r_ax}
              + {{(ROT_HI_W+1-ROT_TERM_W){term_x[ROT_TERM_W-1]}}, term_x};
        sum_y = {r_ay[ROT_HI_W-1], r_ay}
              + {{(ROT_HI_W+1-ROT_TERM_W){term_y[ROT_TERM_W-1]}}, term_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Product low bits leave the accumulator one per cycle into r_lx / r_ly.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mx  <= i_mx;
            r_my  <= i_my;
            r_cos <= i_cos;
            r_sin <= i_sin;
            r_ax  <= '0;
            r_ay  <= '0;
            r_lx  <= '0;
            r_ly  <= '0;
        end else if (r_busy) begin
            r_cos <= {1'b0, r_cos[CFG_W-1:1]};
            r_sin <= {1'b0, r_sin[CFG_W-1:1]};
            r_ax  <= sum_x[ROT_HI_W:1];
            r_ay  <= sum_y[ROT_HI_W:1];
            r_lx  <= {sum_x[0], r_lx[MUL_STEPS-1:1]};
            r_ly  <= {sum_y[0], r_ly[MUL_STEPS-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_rx   = {r_ax, r_lx};
    assign o_ry   = {r_ay, r_ly};

endmodule

// ----- rtl/mrbe_scale.sv -----
// Clamp, bit-serial sensitivity scaling and origin/center offset of one axis.
// Depends on mrbe_pkg; the offset is added after the last multiply step.
module mrbe_scale (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [mrbe_pkg::ROT_W-1:0]      i_val,
    input  logic [mrbe_pkg::CFG_W-1:0]             i_sens,
    input  logic signed [mrbe_pkg::BIAS_W-1:0]     i_bias,
    output logic                                   o_done,
    output logic signed [mrbe_pkg::NUM_W-1:0]      o_num
);
    import mrbe_pkg::*;

    logic                        r_busy;
    logic                        r_done;
    logic [SCL_CNT_W-1:0]        r_cnt;
    logic [CLAMP_W-1:0]          r_b;
    logic [CFG_W-1:0]            r_m;
    logic [SCL_HI_W-1:0]         r_a;
    logic [MUL_STEPS-1:0]        r_l;

    logic signed [ROT_W-1:0]     clamped;
    logic                        bias_step;
    logic [SCL_HI_W:0]           sum;

    always_comb begin
        if (i_val > CLAMP_HI) begin
            clamped = CLAMP_HI;
        end else if (i_val < CLAMP_LO) begin
            clamped = CLAMP_LO;
        end else begin
            clamped = i_val;
        end
    end

    assign bias_step = (r_cnt == SCL_CNT_W'(MUL_STEPS));
    assign sum = {r_a[SCL_HI_W-1], r_a}
               + (r_m[0] ? {{(SCL_HI_W+1-CLAMP_W){r_b[CLAMP_W-1]}}, r_b} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (bias_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_b <= clamped[CLAMP_W-1:0];
            r_m <= i_sens;
            r_a <= '0;
            r_l <= '0;
        end else if (r_busy) begin
            if (bias_step) begin
                // Origin and center sit at bit 16 and above of the product.
                r_a <= r_a + {{(SCL_HI_W-BIAS_W){i_bias[BIAS_W-1]}}, i_bias};
            end else begin
                r_m <= {1'b0, r_m[CFG_W-1:1]};
                r_a <= sum[SCL_HI_W:1];
                r_l <= {sum[0], r_l[MUL_STEPS-1:1]};
            end
        end
    end

    assign o_done = r_done;
    assign o_num  = {r_a, r_l};

endmodule

// ----- rtl/mrbe_div.sv -----
// Normalization of one axis: signed division by a constant divisor with
// truncation toward zero and saturation to Q1.15. Depends on mrbe_pkg.
module mrbe_div (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [mrbe_pkg::NUM_W-1:0]      i_num,
    input  logic                                   i_negate,
    input  logic [mrbe_pkg::DIV_W-1:0]             i_divisor,
    output logic                                   o_done,
    output logic signed [mrbe_pkg::CUR_W-1:0]      o_q
);
    import mrbe_pkg::*;

    localparam logic [1:0] DV_IDLE = 2'd0;
    localparam logic [1:0] DV_CMP  = 2'd1;
    localparam logic [1:0] DV_RUN  = 2'd2;

    logic [1:0]              r_state;
    logic                    r_done;
    logic [DIV_CNT_W-1:0]    r_cnt;
    logic [NUM_W-1:0]        r_mag;
    logic                    r_sign;
    logic                    r_sat;
    logic [REM_W-1:0]        r_rem;
    logic [Q_W-1:0]          r_q;

    logic [NUM_W-1:0]        sat_lim;
    logic [REM_W-1:0]        step_div;
    logic                    ge;
    logic [REM_W-1:0]        rem_sel;
    logic [CUR_W-1:0]        q_ext;

    assign sat_lim  = NUM_W'(i_divisor) << Q_W;
    assign step_div = REM_W'(i_divisor) << (Q_W - 1);
    assign ge       = (r_rem >= step_div);
    assign rem_sel  = ge ? (r_rem - step_div) : r_rem;
    assign q_ext    = {1'b0, r_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_state <= DV_CMP;
            end else begin
                unique case (r_state)
                    DV_IDLE: ;
                    DV_CMP: begin
                        // A saturated axis still runs all steps so both axes finish together.
                        r_cnt   <= '0;
                        r_state <= DV_RUN;
                    end
                    DV_RUN: begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == DIV_CNT_W'(Q_W - 1)) begin
                            r_state <= DV_IDLE;
                            r_done  <= 1'b1;
                        end
                    end
                    default: r_state <= DV_IDLE;
                endcase
            end
        end
    end

    // Restoring division on the magnitude, quotient bits MSB first.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag  <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_sign <= i_num[NUM_W-1] ^ i_negate;
        end else if (r_state == DV_CMP) begin
            r_sat <= (r_mag >= sat_lim);
            r_rem <= r_mag[REM_W-1:0];
            r_q   <= '0;
        end else if (r_state == DV_RUN) begin
            r_rem <= {rem_sel[REM_W-2:0], 1'b0};
            r_q   <= {r_q[Q_W-2:0], ge};
        end
    end

    always_comb begin
        if (r_sat) begin
            o_q = r_sign ? {1'b1, {Q_W{1'b0}}} : {1'b0, {Q_W{1'b1}}};
        end else begin
            o_q = r_sign ? -q_ext : q_ext;
        end
    end

    assign o_done = r_done;

endmodule

// ----- rtl/mouse_report_button_events.sv -----
// Mouse report to button event block: position counters, cursor pipeline
// and event emitter. Depends on mrbe_pkg, mrbe_rot, mrbe_scale, mrbe_div and the defines header.
//
// The slave stream takes one word per HID report or set-position command
// (tuser set). A report adds dx/dy to the wrapping 32-bit counters; for each
// button bit that changed, lowest first, one event word leaves on the master
// stream with the cursor point, tlast marking the report's final event.
// A set-position command clears the counters, loads the origin and emits
// nothing; like a report with no button change, it leaves s_axis_tready high.
// A report with a change runs the cursor point through a bit-serial rotator,
// bit-serial scalers and bit-serial dividers; the emitter then scans one
// button bit per cycle, a changed bit waiting until the output slot is free.
// s_axis_tready is low from the acceptance of such a report until its last
// event is loaded into the output register. That register lets the next word
// be accepted while the final event still waits; a stalled receiver holds
// the emitter. Reset restores register defaults, zeroes counters, origin and
// button history, and drops any pending word. Configuration writes take
// effect at once; the user must make them only while no report is in flight,
// which the block itself does not enforce.
`include "mouse_report_button_events_defines.svh"

module mouse_report_button_events (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // fields from bit 0: dx, dy, buttons, origin_x, origin_y, zero pad
    input  logic [mrbe_pkg::IN_DATA_W-1:0]         s_axis_tdata,
    // action: 0 movement report, 1 set position
    input  logic                                   s_axis_tuser,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // fields from bit 0: device, button_index, pressed, cursor_x, cursor_y
    output logic [mrbe_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    output logic                                   m_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    input  logic                                   i_cfg_we,
    input  logic [mrbe_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mrbe_pkg::CFG_W-1:0]             i_cfg_wdata
);
    import mrbe_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]               r_state;
    logic [1:0]               n_state;

    logic [CFG_W-1:0]         r_rot_cos;
    logic [CFG_W-1:0]         r_rot_sin;
    logic [CFG_W-1:0]         r_sens_x;
    logic [CFG_W-1:0]         r_sens_y;
    logic [CFG_W-1:0]         r_cur_ofs;
    logic [DEV_W-1:0]         r_device_id;

    logic [POS_W-1:0]         r_pos_x;
    logic [POS_W-1:0]         r_pos_y;
    logic [CUR_W-1:0]         r_org_x;
    logic [CUR_W-1:0]         r_org_y;
    logic [NUM_BUTTONS-1:0]   r_last_btn;

    logic [NUM_BUTTONS-1:0]   r_diff;
    logic [NUM_BUTTONS-1:0]   r_now;
    logic [BTN_IDX_W-1:0]     r_idx;
    logic                     r_rot_start;

    logic                     r_m_valid;
    logic                     r_m_last;
    t_out_data                r_m_data;

    t_in_data                 in_word;
    logic                     in_fire;
    logic [NUM_BUTTONS-1:0]   btn_diff;
    logic                     slot_free;
    logic                     emit_shift;
    logic                     emit_load;
    logic [POS_W-1:0]         my;
    logic [BIAS_W-1:0]        bias_x;
    logic [BIAS_W-1:0]        bias_y;

    logic                     rot_done;
    logic signed [ROT_W-1:0]  rx;
    logic signed [ROT_W-1:0]  ry;
    logic                     scl_done_x;
    logic                     scl_done_y;
    logic signed [NUM_W-1:0]  num_x;
    logic signed [NUM_W-1:0]  num_y;
    logic                     div_done_x;
    logic                     div_done_y;
    logic signed [CUR_W-1:0]  q_x;
    logic signed [CUR_W-1:0]  q_y;

    assign in_word       = t_in_data'(s_axis_tdata);
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign btn_diff      = in_word.buttons ^ r_last_btn;
    assign slot_free     = !r_m_valid || m_axis_tready;

    assign my     = r_pos_y + {{(POS_W-CFG_W){r_cur_ofs[CFG_W-1]}}, r_cur_ofs};
    assign bias_x = {{(BIAS_W-CUR_W-2){r_org_x[CUR_W-1]}}, r_org_x, 2'b00} - BIAS_CX;
    assign bias_y = {{(BIAS_W-CUR_W-2){r_org_y[CUR_W-1]}}, r_org_y, 2'b00} - BIAS_CY;

    always_comb begin
        n_state    = r_state;
        emit_shift = 1'b0;
        emit_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && !s_axis_tuser && (btn_diff != '0)) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (div_done_x) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Unchanged bits are skipped; a changed bit waits for the slot.
                if (!r_diff[0] || slot_free) begin
                    emit_shift = 1'b1;
                    emit_load  = r_diff[0];
                    if (r_diff[NUM_BUTTONS-1:1] == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rot_start <= 1'b0;
            r_m_valid   <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_last_btn  <= '0;
            r_rot_cos   <= RST_ROT_COS;
            r_rot_sin   <= RST_ROT_SIN;
            r_sens_x    <= RST_SENS;
            r_sens_y    <= RST_SENS;
            r_cur_ofs   <= RST_CUR_OFS;
            r_device_id <= '0;
        end else begin
            r_state     <= n_state;
            r_rot_start <= (r_state == ST_IDLE) && (n_state == ST_CALC);

            if (emit_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            if (in_fire) begin
                if (s_axis_tuser) begin
                    r_pos_x <= '0;
                    r_pos_y <= '0;
                    r_org_x <= in_word.origin_x;
                    r_org_y <= in_word.origin_y;
                end else begin
                    r_pos_x    <= r_pos_x + {{(POS_W-CUR_W){in_word.dx[CUR_W-1]}}, in_word.dx};
                    r_pos_y    <= r_pos_y + {{(POS_W-CUR_W){in_word.dy[CUR_W-1]}}, in_word.dy};
                    r_last_btn <= in_word.buttons;
                end
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ROT_COS:   r_rot_cos   <= i_cfg_wdata;
                    REG_ROT_SIN:   r_rot_sin   <= i_cfg_wdata;
                    REG_SENS_X:    r_sens_x    <= i_cfg_wdata;
                    REG_SENS_Y:    r_sens_y    <= i_cfg_wdata;
                    REG_CUR_OFS:   r_cur_ofs   <= i_cfg_wdata;
                    REG_DEVICE_ID: r_device_id <= i_cfg_wdata[DEV_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Emitter shift registers and the output word.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_diff <= btn_diff;
            r_now  <= in_word.buttons;
            r_idx  <= '0;
        end else if (emit_shift) begin
            r_diff <= {1'b0, r_diff[NUM_BUTTONS-1:1]};
            r_now  <= {1'b0, r_now[NUM_BUTTONS-1:1]};
            r_idx  <= r_idx + 1'b1;
        end
        if (emit_load) begin
            r_m_data.device       <= r_device_id;
            r_m_data.button_index <= r_idx;
            r_m_data.pressed      <= r_now[0];
            r_m_data.cursor_x     <= q_x;
            r_m_data.cursor_y     <= q_y;
            r_m_last              <= (r_diff[NUM_BUTTONS-1:1] == '0);
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    mrbe_rot u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_rot_start),
        .i_mx    (r_pos_x),
        .i_my    (my),
        .i_cos   (r_rot_cos),
        .i_sin   (r_rot_sin),
        .o_done  (rot_done),
        .o_rx    (rx),
        .o_ry    (ry)
    );

    mrbe_scale u_scale_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rot_done),
        .i_val   (rx),
        .i_sens  (r_sens_x),
        .i_bias  (bias_x),
        .o_done  (scl_done_x),
        .o_num   (num_x)
    );

    mrbe_scale u_scale_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rot_done),
        .i_val   (ry),
        .i_sens  (r_sens_y),
        .i_bias  (bias_y),
        .o_done  (scl_done_y),
        .o_num   (num_y)
    );

    // Screen y grows downward, so the y quotient takes the opposite sign.
    mrbe_div u_div_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (scl_done_x),
        .i_num     (num_x),
        .i_negate  (1'b0),
        .i_divisor (DIV_W'(DIV_X)),
        .o_done    (div_done_x),
        .o_q       (q_x)
    );

    mrbe_div u_div_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (scl_done_y),
        .i_num     (num_y),
        .i_negate  (1'b1),
        .i_divisor (DIV_W'(DIV_Y)),
        .o_done    (div_done_y),
        .o_q       (q_y)
    );

    `MRBE_ASSERT_NEXT(a_setpos_clears, in_fire && s_axis_tuser, (r_pos_x == '0) && (r_pos_y == '0), "set-position left counters nonzero")
    `MRBE_ASSERT_NEXT(a_change_starts, in_fire && !s_axis_tuser && (btn_diff != '0), r_state == ST_CALC, "button change did not start the cursor pipeline")
    `MRBE_ASSERT_IMPL(a_div_aligned, div_done_x || div_done_y, div_done_x && div_done_y && (r_state == ST_CALC), "axis dividers finished out of step")
    `MRBE_ASSERT_IMPL(a_emit_pending, r_state == ST_EMIT, r_diff != '0, "emitter active with no changed button")

endmodule
